FILE: sv/csps_pkg.sv
// Shared types, constants and the CRC-32 byte step of the signature pointer scanner.
`default_nettype none

package csps_pkg;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned OUT_OFFSET_W = 25;
	localparam int unsigned SEEN_W = 26;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] SIG_RESET = 32'h27EA_7FCF;
	localparam logic [ADDR_W-1:0] NOT_FOUND_ADDR = 32'hFFFF_FFFF;
	localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

	// Control from the sequencer to the shared CRC unit.
	typedef struct packed {
		logic init;
		logic step;
	} crc_ctrl_t;

	// One byte of the reflected CRC-32, eight bit steps.
	function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] data);
		logic [31:0] c;
		c = acc ^ {24'd0, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: sv/csps_if.sv
// Input and output channel interfaces of the signature pointer scanner.
`default_nettype none

interface csps_in_if import csps_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] rom_byte;
	logic       last;

	modport source (output valid, output rom_byte, output last, input ready);
	modport sink (input valid, input rom_byte, input last, output ready);
endinterface

interface csps_out_if import csps_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [ADDR_W-1:0]       hook_address;
	logic                    found;
	logic [OUT_OFFSET_W-1:0] match_offset;

	modport source (output valid, output hook_address, output found, output match_offset,
		input ready);
	modport sink (input valid, input hook_address, input found, input match_offset,
		output ready);
endinterface

`default_nettype wire

FILE: sv/csps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module csps_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 120
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/csps_crc_unit.sv
// Shared CRC-32 accumulator that folds in one byte per step.
`default_nettype none

module csps_crc_unit import csps_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire crc_ctrl_t   ctrl,
	input  wire logic [7:0]  data,
	output logic      [31:0] crc
);

	logic [31:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.init) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.step) begin
			crc_q <= crc32_byte(crc_q, data);
		end
	end

	assign crc = crc_q;

endmodule

`default_nettype wire

FILE: sv/crc_signature_pointer_scanner.sv
// Top level of the CRC-32 signature pointer scanner.
//
//  channel  dir  handshake          payload
//  din      in   valid / ready      rom_byte[7:0], last
//  dout     out  valid / ready      hook_address[31:0], found, match_offset[24:0]
//  cfg      in   cfg_we (no stall)  cfg_wdata[31:0] -> signature_crc
//
// A byte that completes a window at an even offset that fits in OFFSET_BITS bits starts a
// CRC check, and no byte is accepted until it ends: the shared CRC unit folds in one byte
// per cycle, fed by the single read port of the window RAM. Every result then passes through
// the emit state.
// The output register holds a result until taken; the next byte is accepted meanwhile, and
// the block only waits in the emit state when a second result meets an untaken first one.
// Reset needs no clearing pass: window bytes are read only after a full window was written.
`default_nettype none

module crc_signature_pointer_scanner import csps_pkg::*; #(
	parameter int unsigned WINDOW_LEN     = 48,
	parameter int unsigned POINTER_OFFSET = 116,
	parameter int unsigned OFFSET_BITS    = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	csps_in_if.sink          din,
	csps_out_if.source       dout,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);

	// The window buffer keeps the pointer word too, so it spans POINTER_OFFSET + 4 bytes.
	localparam int unsigned BUF_LEN = POINTER_OFFSET + 4;
	localparam int unsigned WP_W    = $clog2(BUF_LEN);
	localparam int unsigned ISSUE_W = $clog2(WINDOW_LEN + 1);
	localparam int unsigned CONS_W  = $clog2(WINDOW_LEN);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CRC,
		ST_CMP,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic [31:0]             sig_q;
	logic [WP_W-1:0]         wp_q;
	logic [WP_W-1:0]         rd_addr_q;
	logic [SEEN_W-1:0]       seen_q;
	logic                    match_done_q;
	logic [31:0]             ptr_q;
	logic                    last_q;
	logic [SEEN_W-1:0]       off_q;
	logic [ISSUE_W-1:0]      issue_q;
	logic [CONS_W-1:0]       cons_q;
	logic                    rd_vld_s1;
	logic [ADDR_W-1:0]       res_addr_q;
	logic                    res_found_q;
	logic [OUT_OFFSET_W-1:0] res_off_q;
	logic                    out_valid_q;
	logic [ADDR_W-1:0]       out_addr_q;
	logic                    out_found_q;
	logic [OUT_OFFSET_W-1:0] out_off_q;

	logic                    in_beat;
	logic                    active;
	logic [SEEN_W-1:0]       cur_off;
	logic                    check;
	logic [WP_W-1:0]         wp_next;
	logic [WP_W-1:0]         rd_addr_next;
	logic                    ram_re;
	logic [7:0]              ram_rdata;
	logic [31:0]             crc_acc;
	logic                    crc_match;
	logic [31:0]             ptr_adj;
	logic                    slot_free;
	crc_ctrl_t               crc_ctrl;

	// The signature register is written whenever the write enable is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q <= SIG_RESET;
		end else if (cfg_we) begin
			sig_q <= cfg_wdata;
		end
	end

	assign din.ready = (state_q == ST_IDLE);
	assign in_beat   = din.valid && din.ready;

	// A byte enters the window only while no match is pending and the count has room.
	assign active  = !match_done_q && (seen_q != SEEN_MAX);
	assign cur_off = seen_q - SEEN_W'(BUF_LEN - 1);
	// A window is checked when its pointer word is complete, its offset is even and the
	// offset fits in OFFSET_BITS bits.
	assign check   = active && (seen_q >= SEEN_W'(BUF_LEN - 1)) && !cur_off[0]
		&& ((cur_off >> OFFSET_BITS) == '0);

	assign wp_next      = (wp_q == WP_W'(BUF_LEN - 1)) ? '0 : wp_q + 1'b1;
	assign rd_addr_next = (rd_addr_q == WP_W'(BUF_LEN - 1)) ? '0 : rd_addr_q + 1'b1;
	assign ram_re       = (state_q == ST_CRC) && (issue_q < ISSUE_W'(WINDOW_LEN));

	assign crc_ctrl.init = in_beat && check;
	assign crc_ctrl.step = rd_vld_s1;

	csps_ram #(
		.WIDTH(8),
		.DEPTH(BUF_LEN)
	) u_window_ram (
		.clk   (clk),
		.we    (in_beat && active),
		.waddr (wp_q),
		.wdata (din.rom_byte),
		.re    (ram_re),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	csps_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.data   (ram_rdata),
		.crc    (crc_acc)
	);

	assign crc_match = (crc_acc ^ CRC_INIT) == sig_q;
	// An odd pointer drops bit 0 and gains 4; an even one drops bits 1:0 and gains 8.
	assign ptr_adj   = ptr_q[0] ? ({ptr_q[31:1], 1'b0} + 32'd4) : ({ptr_q[31:2], 2'b00} + 32'd8);
	assign slot_free = !out_valid_q || dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wp_q         <= '0;
			rd_addr_q    <= '0;
			seen_q       <= '0;
			match_done_q <= 1'b0;
			ptr_q        <= '0;
			last_q       <= 1'b0;
			off_q        <= '0;
			issue_q      <= '0;
			cons_q       <= '0;
			rd_vld_s1    <= 1'b0;
			res_addr_q   <= '0;
			res_found_q  <= 1'b0;
			res_off_q    <= '0;
			out_valid_q  <= 1'b0;
			out_addr_q   <= '0;
			out_found_q  <= 1'b0;
			out_off_q    <= '0;
		end else begin
			// In the emit state the output register is refilled below instead.
			if (out_valid_q && dout.ready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			rd_vld_s1 <= ram_re;

			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						last_q <= din.last;
						off_q  <= cur_off;
						if (active) begin
							rd_addr_q <= wp_next;
							ptr_q     <= {din.rom_byte, ptr_q[31:8]};
							// A closing byte with no window to check rearms the scan below.
							if (check || !din.last) begin
								wp_q   <= wp_next;
								seen_q <= seen_q + 1'b1;
							end
						end
						if (check) begin
							issue_q <= '0;
							cons_q  <= '0;
							state_q <= ST_CRC;
						end else if (din.last) begin
							// End of image without a window left to check.
							if (!match_done_q) begin
								res_addr_q  <= NOT_FOUND_ADDR;
								res_found_q <= 1'b0;
								res_off_q   <= '0;
								state_q     <= ST_EMIT;
							end
							wp_q         <= '0;
							seen_q       <= '0;
							match_done_q <= 1'b0;
						end
					end
				end
				ST_CRC: begin
					if (ram_re) begin
						issue_q   <= issue_q + 1'b1;
						rd_addr_q <= rd_addr_next;
					end
					if (rd_vld_s1) begin
						cons_q <= cons_q + 1'b1;
						if (cons_q == CONS_W'(WINDOW_LEN - 1)) begin
							state_q <= ST_CMP;
						end
					end
				end
				ST_CMP: begin
					state_q <= ST_IDLE;
					if (crc_match) begin
						res_addr_q   <= ptr_adj;
						res_found_q  <= 1'b1;
						res_off_q    <= off_q[OUT_OFFSET_W-1:0] & OUT_OFFSET_W'(
							{OFFSET_BITS{1'b1}});
						state_q      <= ST_EMIT;
					end else if (last_q) begin
						res_addr_q  <= NOT_FOUND_ADDR;
						res_found_q <= 1'b0;
						res_off_q   <= '0;
						state_q     <= ST_EMIT;
					end
					// A match on the closing byte still rearms the scan.
					if (last_q) begin
						wp_q         <= '0;
						seen_q       <= '0;
						match_done_q <= 1'b0;
					end else if (crc_match) begin
						match_done_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_addr_q  <= res_addr_q;
						out_found_q <= res_found_q;
						out_off_q   <= res_off_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign dout.valid        = out_valid_q;
	assign dout.hook_address = out_addr_q;
	assign dout.found        = out_found_q;
	assign dout.match_offset = out_off_q;

	// Read data only comes back while a window is being folded.
	a_rd_in_crc: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_CRC))
		else $error("window read data outside the CRC pass");

	// The CRC pass never issues more reads than the window has bytes.
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q <= ISSUE_W'(WINDOW_LEN))
		else $error("CRC pass issued too many reads");

	// An adjusted pointer is always even.
	a_found_even: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.found) |-> !dout.hook_address[0])
		else $error("matched hook address is odd");

	// A miss beat carries the fixed not-found payload.
	a_miss_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && !dout.found) |->
			((dout.hook_address == NOT_FOUND_ADDR) && (dout.match_offset == '0)))
		else $error("not-found beat with a wrong payload");

endmodule

`default_nettype wire
